// ----- rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the byte deque: request codes, controller
// states and the result item passed from the controller to the output stage.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int BYTE_W  = 8;
    localparam int REQ_W   = 3;
    localparam int COUNT_W = 15;
    localparam int LEVEL_W = 15;

    localparam logic [BYTE_W-1:0] NL_BYTE = 8'h0A;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_POP    = 3'd1,
        REQ_PEEK   = 3'd2,
        REQ_LINE   = 3'd3,
        REQ_UNGET  = 3'd4,
        REQ_SKIP   = 3'd5,
        REQ_CHOP   = 3'd6,
        REQ_CLEAR  = 3'd7
    } bdq_req_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_EMIT,
        S_ONE
    } bdq_state_t;

    // one result item
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               out_valid;
        logic               last;
        logic [LEVEL_W-1:0] level;
        logic               has_line;
        logic               full_error;
    } bdq_result_t;

endpackage

// ----- rtl/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// bdq_ram
// Ring storage of the deque: one write port, one read port with registered
// read data, held while no read is issued.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [bdq_pkg::BYTE_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [bdq_pkg::BYTE_W-1:0] rdata
);
    import bdq_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request sequencer: single-byte updates, newline scan over the bytes being
// removed, commit of front/level/newline count, then byte-by-byte delivery.
// ----------------------------------------------------------------------------
module bdq_ctrl #(
    parameter int DEPTH     = 16384,
    parameter int MAX_BURST = 64,
    parameter int AW        = 14
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request side
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bdq_pkg::REQ_W-1:0]   s_req_type,
    input  logic [bdq_pkg::BYTE_W-1:0]  s_in_byte,
    input  logic [bdq_pkg::COUNT_W-1:0] s_count,
    // result side
    output logic                        o_valid,
    input  logic                        o_ready,
    output bdq_pkg::bdq_result_t        o_res,
    // byte memory
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [bdq_pkg::BYTE_W-1:0]  mem_wdata,
    output logic                        mem_re,
    output logic [AW-1:0]               mem_raddr,
    input  logic [bdq_pkg::BYTE_W-1:0]  mem_rdata
);
    import bdq_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;

    // (base + off) modulo depth, both below depth
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + {1'b0, off};
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    bdq_state_t        state_reg, state_next;
    bdq_req_t          op_reg, op_next;
    logic [AW-1:0]     front_reg, front_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [LW-1:0]     fill_reg, fill_next;
    logic [LW-1:0]     nl_reg, nl_next;
    logic [LW-1:0]     found_reg, found_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     off_reg, off_next;
    logic [CW-1:0]     chk_reg, chk_next;
    logic              pend_reg, pend_next;
    logic              err_reg, err_next;

    bdq_req_t          req;
    logic [CW-1:0]     cnt_ext;
    logic [CW-1:0]     fill_ext;
    logic [CW-1:0]     burst_n;
    logic              full;
    logic              in_nl;
    logic [AW-1:0]     front_dec;
    logic              accept;
    logic              scan_issue;
    logic              scan_nl;
    logic              scan_done;
    logic [CW-1:0]     n_fin;
    logic [LW-1:0]     found_tot;
    logic              emit_last;
    logic [CW-1:0]     level_ext;

    // request decode helpers
    assign req       = bdq_req_t'(s_req_type);
    assign cnt_ext   = CW'(s_count);
    assign fill_ext  = CW'(fill_reg);
    assign full      = (fill_reg >= LW'(DEPTH));
    assign in_nl     = (s_in_byte == NL_BYTE);
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;
    assign accept    = s_valid && s_ready;

    // burst length cut to the burst limit and to the level
    always_comb begin
        burst_n = cnt_ext;
        if (burst_n > CW'(MAX_BURST)) begin
            burst_n = CW'(MAX_BURST);
        end
        if (burst_n > fill_ext) begin
            burst_n = fill_ext;
        end
    end

    // scan bookkeeping
    assign scan_issue = (off_reg < n_reg);
    assign scan_nl    = pend_reg && (mem_rdata == NL_BYTE);
    assign scan_done  = pend_reg && (((op_reg == REQ_LINE) && scan_nl) ||
                                     (chk_reg == n_reg - 1'b1));
    assign n_fin      = chk_reg + 1'b1;
    assign found_tot  = found_reg + LW'(scan_nl);
    assign emit_last  = (off_reg == n_reg - 1'b1);

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        front_next = front_reg;
        base_next  = base_reg;
        fill_next  = fill_reg;
        nl_next    = nl_reg;
        found_next = found_reg;
        n_next     = n_reg;
        off_next   = off_reg;
        chk_next   = chk_reg;
        pend_next  = 1'b0;
        err_next   = err_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next    = req;
                    err_next   = 1'b0;
                    base_next  = front_reg;
                    off_next   = '0;
                    found_next = '0;
                    state_next = S_ONE;
                    unique case (req) inside
                        REQ_APPEND: begin
                            if (full) begin
                                err_next = 1'b1;
                            end else begin
                                fill_next = fill_reg + 1'b1;
                                nl_next   = nl_reg + LW'(in_nl);
                            end
                        end
                        REQ_UNGET: begin
                            if (full) begin
                                err_next = 1'b1;
                            end else begin
                                front_next = front_dec;
                                fill_next  = fill_reg + 1'b1;
                                nl_next    = nl_reg + LW'(in_nl);
                            end
                        end
                        REQ_CLEAR: begin
                            front_next = '0;
                            fill_next  = '0;
                            nl_next    = '0;
                        end
                        REQ_SKIP, REQ_CHOP: begin
                            n_next = cnt_ext;
                            if (cnt_ext >= fill_ext) begin
                                front_next = '0;
                                fill_next  = '0;
                                nl_next    = '0;
                            end else if (cnt_ext != '0) begin
                                state_next = S_SCAN;
                                if (req == REQ_CHOP) begin
                                    base_next = ring_add(front_reg, fill_ext - cnt_ext);
                                end
                            end
                        end
                        REQ_POP, REQ_LINE: begin
                            n_next = burst_n;
                            if (burst_n != '0) begin
                                state_next = S_SCAN;
                            end
                        end
                        REQ_PEEK: begin
                            n_next = burst_n;
                            if (burst_n != '0) begin
                                state_next = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_issue) begin
                    off_next  = off_reg + 1'b1;
                    chk_next  = off_reg;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    found_next = found_tot;
                end
                // commit of the removal once the last byte is checked
                if (scan_done) begin
                    pend_next = 1'b0;
                    off_next  = '0;
                    n_next    = n_fin;
                    if (op_reg == REQ_CHOP) begin
                        fill_next = fill_reg - LW'(n_fin);
                        nl_next   = nl_reg - found_tot;
                    end else if (n_fin >= fill_ext) begin
                        front_next = '0;
                        fill_next  = '0;
                        nl_next    = '0;
                    end else begin
                        front_next = ring_add(front_reg, n_fin);
                        fill_next  = fill_reg - LW'(n_fin);
                        nl_next    = nl_reg - found_tot;
                    end
                    unique case (op_reg) inside
                        REQ_POP, REQ_LINE: state_next = S_RD;
                        default:           state_next = S_ONE;
                    endcase
                end
            end
            S_RD: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (o_ready) begin
                    off_next   = off_reg + 1'b1;
                    state_next = emit_last ? S_IDLE : S_RD;
                end
            end
            S_ONE: begin
                if (o_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // level masked to its field width
    assign level_ext = CW'(fill_reg);

    // outputs and memory accesses
    always_comb begin
        s_ready          = 1'b0;
        o_valid          = 1'b0;
        o_res.out_byte   = '0;
        o_res.out_valid  = 1'b0;
        o_res.last       = 1'b1;
        o_res.level      = level_ext[LEVEL_W-1:0];
        o_res.has_line   = (nl_reg != '0);
        o_res.full_error = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = ring_add(front_reg, fill_ext);
        mem_wdata        = s_in_byte;
        mem_re           = 1'b0;
        mem_raddr        = ring_add(base_reg, off_reg);
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && !full && (req == REQ_APPEND || req == REQ_UNGET)) begin
                    mem_we = 1'b1;
                end
                if (req == REQ_UNGET) begin
                    mem_waddr = front_dec;
                end
            end
            S_SCAN: begin
                mem_re = scan_issue;
            end
            S_RD: begin
                mem_re = 1'b1;
            end
            S_EMIT: begin
                o_valid         = 1'b1;
                o_res.out_byte  = mem_rdata;
                o_res.out_valid = 1'b1;
                o_res.last      = emit_last;
            end
            S_ONE: begin
                o_valid          = 1'b1;
                o_res.full_error = err_reg;
            end
            default: begin
                o_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            fill_reg  <= '0;
            nl_reg    <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            fill_reg  <= fill_next;
            nl_reg    <= nl_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        base_reg  <= base_next;
        found_reg <= found_next;
        n_reg     <= n_next;
        off_reg   <= off_next;
        chk_reg   <= chk_next;
        err_reg   <= err_next;
    end

endmodule

// ----- rtl/byte_deque_with_unget_and_lines_unit.sv -----
// ----------------------------------------------------------------------------
// byte_deque_with_unget_and_lines_unit
// Fixed-capacity byte deque with append, unget, pop, peek, line read, skip,
// chop and clear, held as a ring in one synchronous byte memory.
//
//   channel   | ports                                   | item
//   ----------+-----------------------------------------+----------------------
//   request   | s_valid s_ready s_req_type s_in_byte    | one request
//             | s_count                                 |
//   result    | m_valid m_ready m_out_byte m_out_valid  | one byte or status
//             | m_last m_level m_has_line m_full_error  |
//
// Append, unget, clear and empty requests give one status result. Pop and
// line read first scan for newlines, then deliver each byte through a read
// state and an emit state; peek skips the scan. Skip and chop below the level
// scan one byte per cycle through the single memory read port. Reset empties
// the deque at once; the memory is not cleared. A stalled result waits in
// the output register and a new request is taken only once the last result
// of the previous one has been handed to the output register.
// ----------------------------------------------------------------------------
module byte_deque_with_unget_and_lines_unit #(
    parameter int DEPTH     = 16384,
    parameter int MAX_BURST = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bdq_pkg::REQ_W-1:0]   s_req_type,
    input  logic [bdq_pkg::BYTE_W-1:0]  s_in_byte,
    input  logic [bdq_pkg::COUNT_W-1:0] s_count,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bdq_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                        m_out_valid,
    output logic                        m_last,
    output logic [bdq_pkg::LEVEL_W-1:0] m_level,
    output logic                        m_has_line,
    output logic                        m_full_error
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              ctrl_valid;
    logic              ctrl_ready;
    bdq_result_t       ctrl_res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    logic              obuf_valid_reg, obuf_valid_next;
    bdq_result_t       obuf_reg;

    // byte memory
    bdq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // request sequencer
    bdq_ctrl #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST),
        .AW        (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_in_byte  (s_in_byte),
        .s_count    (s_count),
        .o_valid    (ctrl_valid),
        .o_ready    (ctrl_ready),
        .o_res      (ctrl_res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // output register
    assign ctrl_ready = !obuf_valid_reg || m_ready;

    always_comb begin
        obuf_valid_next = obuf_valid_reg;
        if (ctrl_valid && ctrl_ready) begin
            obuf_valid_next = 1'b1;
        end else if (m_ready) begin
            obuf_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obuf_valid_reg <= 1'b0;
        end else begin
            obuf_valid_reg <= obuf_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_valid && ctrl_ready) begin
            obuf_reg <= ctrl_res;
        end
    end

    assign m_valid      = obuf_valid_reg;
    assign m_out_byte   = obuf_reg.out_byte;
    assign m_out_valid  = obuf_reg.out_valid;
    assign m_last       = obuf_reg.last;
    assign m_level      = obuf_reg.level;
    assign m_has_line   = obuf_reg.has_line;
    assign m_full_error = obuf_reg.full_error;

endmodule
